[sv/lu_pivot_linear_solver_defines.svh]
// Assertion macros shared by the solver modules.
`ifndef LU_PIVOT_LINEAR_SOLVER_DEFINES_SVH
`define LU_PIVOT_LINEAR_SOLVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LUPS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LUPS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/lups_pkg.sv]
package lups_pkg;

	localparam int MAX_N     = 16;
	localparam int IDX_W     = $clog2(MAX_N);
	localparam int CNT_W     = IDX_W + 1;
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int MAT_D     = MAX_N * MAX_N;
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int DIV_W     = DATA_W + FRAC_BITS;
	localparam int SUM_W     = DATA_W + IDX_W + 1;
	localparam int SIZE_W    = 5;
	localparam int THR_W     = 16;
	localparam int FUNC_W    = 2;
	localparam int MAG_W     = DATA_W + 1;

	localparam logic [FUNC_W-1:0] FN_LOAD_M = 2'd0;
	localparam logic [FUNC_W-1:0] FN_LOAD_B = 2'd1;
	localparam logic [FUNC_W-1:0] FN_SOLVE  = 2'd2;

	localparam logic signed [PROD_W-1:0] S_MAX = 64'sd2147483647;
	localparam logic signed [PROD_W-1:0] S_MIN = -64'sd2147483648;

	typedef enum logic [2:0] {
		MW_IN, MW_MA, MW_MB, MW_QUO, MW_UPD
	} msel_t;

	typedef enum logic [2:0] {
		VW_RHS, VW_VA, VW_VB, VW_ACC, VW_QUO
	} vsel_t;

	typedef enum logic {
		RW_IN, RW_VA
	} rsel_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_MAG_INIT, OP_MAG_CMP, OP_PIV, OP_DIV_L, OP_DIV_B, OP_MUL_MB,
		OP_MUL_MV, OP_ACC_LD, OP_ACC_SUB, OP_SUM_CLR, OP_SUM_ADD, OP_L_LD
	} dpop_t;

	typedef struct packed {
		logic              m_ra_en;
		logic [ADDR_W-1:0] m_ra;
		logic              m_rb_en;
		logic [ADDR_W-1:0] m_rb;
		logic              m_we;
		logic [ADDR_W-1:0] m_wa;
		msel_t             m_ws;
		logic              v_ra_en;
		logic [IDX_W-1:0]  v_ra;
		logic              v_rb_en;
		logic [IDX_W-1:0]  v_rb;
		logic              v_we;
		logic [IDX_W-1:0]  v_wa;
		vsel_t             v_ws;
		logic              r_re;
		logic [IDX_W-1:0]  r_ra;
		logic              r_we;
		logic [IDX_W-1:0]  r_wa;
		rsel_t             r_ws;
		dpop_t             op;
		logic              o_ld;
		logic              o_sing;
		logic [IDX_W-1:0]  o_idx;
		logic              o_last;
	} cmd_t;

	typedef struct packed {
		logic gt;
		logic sing;
		logic div_busy;
		logic div_done;
		logic out_busy;
	} sts_t;

	function automatic logic signed [DATA_W-1:0] sat64(input logic signed [PROD_W-1:0] v);
		if (v > S_MAX) begin
			return DATA_W'(S_MAX);
		end
		if (v < S_MIN) begin
			return DATA_W'(S_MIN);
		end
		return DATA_W'(v);
	endfunction

	function automatic logic signed [DATA_W-1:0] fx_scale(input logic signed [PROD_W-1:0] p);
		return sat64(p >>> FRAC_BITS);
	endfunction

endpackage

[sv/lups_div.sv]
module lups_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [lups_pkg::DATA_W-1:0]  a,
	input  logic signed [lups_pkg::DATA_W-1:0]  b,
	output logic                                busy,
	output logic                                done,
	output logic signed [lups_pkg::DATA_W-1:0]  quo
);
	import lups_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic [DIV_W-1:0]  dvd_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DATA_W-1:0] rem_q;
	logic [CW-1:0]     cnt_q;
	logic              sign_q;
	logic              busy_q;
	logic              done_q;
	logic [DATA_W-1:0] ua;
	logic [DATA_W-1:0] ub;
	logic [DATA_W:0]   trial;
	logic              fits;

	assign ua    = a[DATA_W-1] ? (~a + 1'b1) : a;
	assign ub    = b[DATA_W-1] ? (~b + 1'b1) : b;
	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sign_q <= a[DATA_W-1] ^ b[DATA_W-1];
			dvd_q  <= {ua, {FRAC_BITS{1'b0}}};
			dvs_q  <= ub;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DATA_W'(trial - {1'b0, dvs_q}) : DATA_W'(trial);
			dvd_q <= {dvd_q[DIV_W-2:0], fits};
		end
	end

	always_comb begin
		if (!sign_q) begin
			quo = (dvd_q > DIV_W'(S_MAX)) ? DATA_W'(S_MAX) : DATA_W'(dvd_q);
		end else begin
			quo = (dvd_q > DIV_W'(-S_MIN)) ? DATA_W'(S_MIN) : DATA_W'(~dvd_q + 1'b1);
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

[sv/lups_ctrl.sv]
`include "lu_pivot_linear_solver_defines.svh"

module lups_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lups_pkg::FUNC_W-1:0]   func,
	input  logic [lups_pkg::IDX_W-1:0]    row_index,
	input  logic [lups_pkg::IDX_W-1:0]    col_index,
	input  logic [lups_pkg::SIZE_W-1:0]   matrix_size,
	input  lups_pkg::sts_t                sts,
	output lups_pkg::cmd_t                cmd
);
	import lups_pkg::*;

	localparam int NST = 43;

	typedef enum logic [NST-1:0] {
		ST_IDLE   = NST'(1) << 0,
		ST_CP_RD  = NST'(1) << 1,
		ST_CP_WR  = NST'(1) << 2,
		ST_PS_RD0 = NST'(1) << 3,
		ST_PS_INI = NST'(1) << 4,
		ST_PS_RD  = NST'(1) << 5,
		ST_PS_CMP = NST'(1) << 6,
		ST_PS_CHK = NST'(1) << 7,
		ST_SW_RD  = NST'(1) << 8,
		ST_SW_W1  = NST'(1) << 9,
		ST_SW_W2  = NST'(1) << 10,
		ST_VS_RD  = NST'(1) << 11,
		ST_VS_W1  = NST'(1) << 12,
		ST_VS_W2  = NST'(1) << 13,
		ST_PV_RD  = NST'(1) << 14,
		ST_PV_LD  = NST'(1) << 15,
		ST_L_RD   = NST'(1) << 16,
		ST_L_DIV  = NST'(1) << 17,
		ST_L_WAIT = NST'(1) << 18,
		ST_L_WR   = NST'(1) << 19,
		ST_U_RD   = NST'(1) << 20,
		ST_U_MUL  = NST'(1) << 21,
		ST_U_WR   = NST'(1) << 22,
		ST_FC_RD  = NST'(1) << 23,
		ST_FC_MAG = NST'(1) << 24,
		ST_FC_CHK = NST'(1) << 25,
		ST_F_INI  = NST'(1) << 26,
		ST_F_LD   = NST'(1) << 27,
		ST_F_RD   = NST'(1) << 28,
		ST_F_MUL  = NST'(1) << 29,
		ST_F_ACC  = NST'(1) << 30,
		ST_F_WR   = NST'(1) << 31,
		ST_B_INI  = NST'(1) << 32,
		ST_B_RD   = NST'(1) << 33,
		ST_B_MUL  = NST'(1) << 34,
		ST_B_ACC  = NST'(1) << 35,
		ST_B_D    = NST'(1) << 36,
		ST_B_DIV  = NST'(1) << 37,
		ST_B_WAIT = NST'(1) << 38,
		ST_B_WR   = NST'(1) << 39,
		ST_O_RD   = NST'(1) << 40,
		ST_O_WR   = NST'(1) << 41,
		ST_SG     = NST'(1) << 42
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
	logic [IDX_W-1:0] best_q, best_d;
	logic [CNT_W-1:0] n;

	function automatic logic [ADDR_W-1:0] cadr(input logic [CNT_W-1:0] r,
		input logic [CNT_W-1:0] c);
		return {r[IDX_W-1:0], c[IDX_W-1:0]};
	endfunction

	always_comb begin
		if (matrix_size == '0) begin
			n = CNT_W'(1);
		end else if ({1'b0, matrix_size} > (SIZE_W + 1)'(MAX_N)) begin
			n = CNT_W'(MAX_N);
		end else begin
			n = CNT_W'(matrix_size);
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		k_d     = k_q;
		best_d  = best_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (func)
						FN_LOAD_M: begin
							cmd.m_we = 1'b1;
							cmd.m_wa = {row_index, col_index};
							cmd.m_ws = MW_IN;
						end
						FN_LOAD_B: begin
							cmd.r_we = 1'b1;
							cmd.r_wa = row_index;
							cmd.r_ws = RW_IN;
						end
						FN_SOLVE: begin
							k_d     = '0;
							state_d = ST_CP_RD;
						end
						default: ;
					endcase
				end
			end
			ST_CP_RD: begin
				cmd.r_re = 1'b1;
				cmd.r_ra = k_q[IDX_W-1:0];
				state_d  = ST_CP_WR;
			end
			ST_CP_WR: begin
				cmd.v_we = 1'b1;
				cmd.v_wa = k_q[IDX_W-1:0];
				cmd.v_ws = VW_RHS;
				k_d      = k_q + 1'b1;
				if (k_q + 1'b1 == n) begin
					i_d     = '0;
					state_d = (n == CNT_W'(1)) ? ST_FC_RD : ST_PS_RD0;
				end else begin
					state_d = ST_CP_RD;
				end
			end
			ST_PS_RD0: begin
				cmd.m_ra_en = 1'b1;
				cmd.m_ra    = cadr(i_q, i_q);
				state_d     = ST_PS_INI;
			end
			ST_PS_INI: begin
				cmd.op  = OP_MAG_INIT;
				best_d  = i_q[IDX_W-1:0];
				j_d     = i_q + 1'b1;
				state_d = ST_PS_RD;
			end
			ST_PS_RD: begin
				cmd.m_ra_en = 1'b1;
				cmd.m_ra    = cadr(j_q, i_q);
				state_d     = ST_PS_CMP;
			end
			ST_PS_CMP: begin
				cmd.op = OP_MAG_CMP;
				if (sts.gt) begin
					best_d = j_q[IDX_W-1:0];
				end
				j_d     = j_q + 1'b1;
				state_d = (j_q + 1'b1 == n) ? ST_PS_CHK : ST_PS_RD;
			end
			ST_PS_CHK: begin
				if (sts.sing) begin
					state_d = ST_SG;
				end else if (best_q != i_q[IDX_W-1:0]) begin
					k_d     = '0;
					state_d = ST_SW_RD;
				end else begin
					state_d = ST_PV_RD;
				end
			end
			ST_SW_RD: begin
				cmd.m_ra_en = 1'b1;
				cmd.m_ra    = cadr(i_q, k_q);
				cmd.m_rb_en = 1'b1;
				cmd.m_rb    = {best_q, k_q[IDX_W-1:0]};
				state_d     = ST_SW_W1;
			end
			ST_SW_W1: begin
				cmd.m_we = 1'b1;
				cmd.m_wa = cadr(i_q, k_q);
				cmd.m_ws = MW_MB;
				state_d  = ST_SW_W2;
			end
			ST_SW_W2: begin
				cmd.m_we = 1'b1;
				cmd.m_wa = {best_q, k_q[IDX_W-1:0]};
				cmd.m_ws = MW_MA;
				k_d      = k_q + 1'b1;
				state_d  = (k_q + 1'b1 == n) ? ST_VS_RD : ST_SW_RD;
			end
			ST_VS_RD: begin
				cmd.v_ra_en = 1'b1;
				cmd.v_ra    = i_q[IDX_W-1:0];
				cmd.v_rb_en = 1'b1;
				cmd.v_rb    = best_q;
				state_d     = ST_VS_W1;
			end
			ST_VS_W1: begin
				cmd.v_we = 1'b1;
				cmd.v_wa = i_q[IDX_W-1:0];
				cmd.v_ws = VW_VB;
				state_d  = ST_VS_W2;
			end
			ST_VS_W2: begin
				cmd.v_we = 1'b1;
				cmd.v_wa = best_q;
				cmd.v_ws = VW_VA;
				state_d  = ST_PV_RD;
			end
			ST_PV_RD: begin
				cmd.m_ra_en = 1'b1;
				cmd.m_ra    = cadr(i_q, i_q);
				state_d     = ST_PV_LD;
			end
			ST_PV_LD: begin
				cmd.op  = OP_PIV;
				j_d     = i_q + 1'b1;
				state_d = ST_L_RD;
			end
			ST_L_RD: begin
				cmd.m_ra_en = 1'b1;
				cmd.m_ra    = cadr(j_q, i_q);
				state_d     = ST_L_DIV;
			end
			ST_L_DIV: begin
				cmd.op  = OP_DIV_L;
				state_d = ST_L_WAIT;
			end
			ST_L_WAIT: begin
				if (sts.div_done) begin
					state_d = ST_L_WR;
				end
			end
			ST_L_WR: begin
				cmd.m_we = 1'b1;
				cmd.m_wa = cadr(j_q, i_q);
				cmd.m_ws = MW_QUO;
				cmd.op   = OP_L_LD;
				k_d      = i_q + 1'b1;
				state_d  = ST_U_RD;
			end
			ST_U_RD: begin
				cmd.m_ra_en = 1'b1;
				cmd.m_ra    = cadr(j_q, k_q);
				cmd.m_rb_en = 1'b1;
				cmd.m_rb    = cadr(i_q, k_q);
				state_d     = ST_U_MUL;
			end
			ST_U_MUL: begin
				cmd.op  = OP_MUL_MB;
				state_d = ST_U_WR;
			end
			ST_U_WR: begin
				cmd.m_we = 1'b1;
				cmd.m_wa = cadr(j_q, k_q);
				cmd.m_ws = MW_UPD;
				k_d      = k_q + 1'b1;
				if (k_q + 1'b1 != n) begin
					state_d = ST_U_RD;
				end else if (j_q + 1'b1 != n) begin
					j_d     = j_q + 1'b1;
					state_d = ST_L_RD;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = (i_q + 2'd2 == n) ? ST_FC_RD : ST_PS_RD0;
				end
			end
			ST_FC_RD: begin
				cmd.m_ra_en = 1'b1;
				cmd.m_ra    = cadr(n - 1'b1, n - 1'b1);
				state_d     = ST_FC_MAG;
			end
			ST_FC_MAG: begin
				cmd.op  = OP_MAG_INIT;
				state_d = ST_FC_CHK;
			end
			ST_FC_CHK: begin
				i_d     = '0;
				state_d = sts.sing ? ST_SG : ST_F_INI;
			end
			ST_F_INI: begin
				cmd.v_ra_en = 1'b1;
				cmd.v_ra    = i_q[IDX_W-1:0];
				state_d     = ST_F_LD;
			end
			ST_F_LD: begin
				cmd.op  = OP_ACC_LD;
				j_d     = '0;
				state_d = (i_q == '0) ? ST_F_WR : ST_F_RD;
			end
			ST_F_RD: begin
				cmd.m_ra_en = 1'b1;
				cmd.m_ra    = cadr(i_q, j_q);
				cmd.v_rb_en = 1'b1;
				cmd.v_rb    = j_q[IDX_W-1:0];
				state_d     = ST_F_MUL;
			end
			ST_F_MUL: begin
				cmd.op  = OP_MUL_MV;
				state_d = ST_F_ACC;
			end
			ST_F_ACC: begin
				cmd.op  = OP_ACC_SUB;
				j_d     = j_q + 1'b1;
				state_d = (j_q + 1'b1 == i_q) ? ST_F_WR : ST_F_RD;
			end
			ST_F_WR: begin
				cmd.v_we = 1'b1;
				cmd.v_wa = i_q[IDX_W-1:0];
				cmd.v_ws = VW_ACC;
				if (i_q + 1'b1 == n) begin
					state_d = ST_B_INI;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = ST_F_INI;
				end
			end
			ST_B_INI: begin
				cmd.op  = OP_SUM_CLR;
				j_d     = i_q + 1'b1;
				state_d = (i_q + 1'b1 == n) ? ST_B_D : ST_B_RD;
			end
			ST_B_RD: begin
				cmd.m_ra_en = 1'b1;
				cmd.m_ra    = cadr(i_q, j_q);
				cmd.v_rb_en = 1'b1;
				cmd.v_rb    = j_q[IDX_W-1:0];
				state_d     = ST_B_MUL;
			end
			ST_B_MUL: begin
				cmd.op  = OP_MUL_MV;
				state_d = ST_B_ACC;
			end
			ST_B_ACC: begin
				cmd.op  = OP_SUM_ADD;
				j_d     = j_q + 1'b1;
				state_d = (j_q + 1'b1 == n) ? ST_B_D : ST_B_RD;
			end
			ST_B_D: begin
				cmd.m_ra_en = 1'b1;
				cmd.m_ra    = cadr(i_q, i_q);
				cmd.v_ra_en = 1'b1;
				cmd.v_ra    = i_q[IDX_W-1:0];
				state_d     = ST_B_DIV;
			end
			ST_B_DIV: begin
				cmd.op  = OP_DIV_B;
				state_d = ST_B_WAIT;
			end
			ST_B_WAIT: begin
				if (sts.div_done) begin
					state_d = ST_B_WR;
				end
			end
			ST_B_WR: begin
				cmd.v_we = 1'b1;
				cmd.v_wa = i_q[IDX_W-1:0];
				cmd.v_ws = VW_QUO;
				if (i_q == '0) begin
					k_d     = '0;
					state_d = ST_O_RD;
				end else begin
					i_d     = i_q - 1'b1;
					state_d = ST_B_INI;
				end
			end
			ST_O_RD: begin
				if (!sts.out_busy) begin
					cmd.v_ra_en = 1'b1;
					cmd.v_ra    = k_q[IDX_W-1:0];
					state_d     = ST_O_WR;
				end
			end
			ST_O_WR: begin
				cmd.r_we   = 1'b1;
				cmd.r_wa   = k_q[IDX_W-1:0];
				cmd.r_ws   = RW_VA;
				cmd.o_ld   = 1'b1;
				cmd.o_idx  = k_q[IDX_W-1:0];
				cmd.o_last = (k_q + 1'b1 == n);
				k_d        = k_q + 1'b1;
				state_d    = (k_q + 1'b1 == n) ? ST_IDLE : ST_O_RD;
			end
			ST_SG: begin
				if (!sts.out_busy) begin
					cmd.o_ld   = 1'b1;
					cmd.o_sing = 1'b1;
					cmd.o_last = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			best_q  <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			best_q  <= best_d;
		end
	end

	`LUPS_ASSERT_IMP(a_wait_div, state_q == ST_L_WAIT || state_q == ST_B_WAIT,
		sts.div_busy || sts.div_done, "Waiting on a divider that is not running.")

endmodule

[sv/lups_dp.sv]
`include "lu_pivot_linear_solver_defines.svh"

module lups_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lups_pkg::cmd_t                      cmd,
	input  logic signed [lups_pkg::DATA_W-1:0]  value,
	input  logic [lups_pkg::THR_W-1:0]          pivot_threshold,
	output lups_pkg::sts_t                      sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [lups_pkg::IDX_W-1:0]          sol_index,
	output logic signed [lups_pkg::DATA_W-1:0]  sol_value,
	output logic                                status,
	output logic                                last
);
	import lups_pkg::*;

	logic [DATA_W-1:0] mat_mem [MAT_D];
	logic [DATA_W-1:0] vec_mem [MAX_N];
	logic [DATA_W-1:0] rhs_mem [MAX_N];

	logic signed [DATA_W-1:0] ma_q, mb_q, va_q, vb_q, rr_q;
	logic signed [DATA_W-1:0] piv_q, l_q, acc_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [MAG_W-1:0]         bmag_q;

	logic signed [DATA_W-1:0] ms, upd, divb_num, quo, div_a, div_b;
	logic signed [DATA_W-1:0] mw, vw, rw;
	logic [MAG_W-1:0]         ma_mag;
	logic                     div_start, div_busy, div_done;

	logic                     out_valid_q, status_q, last_q;
	logic [IDX_W-1:0]         sol_index_q;
	logic signed [DATA_W-1:0] sol_value_q;

	assign ma_mag   = ma_q[DATA_W-1] ? (MAG_W'(~ma_q) + 1'b1) & {1'b0, {DATA_W{1'b1}}}
		: MAG_W'(unsigned'(ma_q));
	assign ms       = fx_scale(prod_q);
	assign upd      = sat64(PROD_W'(ma_q) - PROD_W'(ms));
	assign divb_num = sat64(PROD_W'(va_q) - PROD_W'(sum_q));

	assign div_start = (cmd.op == OP_DIV_L) || (cmd.op == OP_DIV_B);
	assign div_a     = (cmd.op == OP_DIV_B) ? divb_num : ma_q;
	assign div_b     = (cmd.op == OP_DIV_B) ? ma_q : piv_q;

	lups_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (div_a),
		.b      (div_b),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (quo)
	);

	always_comb begin
		case (cmd.m_ws)
			MW_IN:   mw = value;
			MW_MA:   mw = ma_q;
			MW_MB:   mw = mb_q;
			MW_QUO:  mw = quo;
			MW_UPD:  mw = upd;
			default: mw = value;
		endcase
		case (cmd.v_ws)
			VW_RHS:  vw = rr_q;
			VW_VA:   vw = va_q;
			VW_VB:   vw = vb_q;
			VW_ACC:  vw = acc_q;
			VW_QUO:  vw = quo;
			default: vw = rr_q;
		endcase
		rw = (cmd.r_ws == RW_VA) ? va_q : value;
	end

	always_ff @(posedge clk) begin
		if (cmd.m_we) begin
			mat_mem[cmd.m_wa] <= mw;
		end
		if (cmd.m_ra_en) begin
			ma_q <= mat_mem[cmd.m_ra];
		end
		if (cmd.m_rb_en) begin
			mb_q <= mat_mem[cmd.m_rb];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.v_we) begin
			vec_mem[cmd.v_wa] <= vw;
		end
		if (cmd.v_ra_en) begin
			va_q <= vec_mem[cmd.v_ra];
		end
		if (cmd.v_rb_en) begin
			vb_q <= vec_mem[cmd.v_rb];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.r_we) begin
			rhs_mem[cmd.r_wa] <= rw;
		end
		if (cmd.r_re) begin
			rr_q <= rhs_mem[cmd.r_ra];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_MAG_INIT: bmag_q <= ma_mag;
			OP_MAG_CMP: begin
				if (ma_mag > bmag_q) begin
					bmag_q <= ma_mag;
				end
			end
			OP_PIV:     piv_q  <= ma_q;
			OP_MUL_MB:  prod_q <= PROD_W'(l_q) * PROD_W'(mb_q);
			OP_MUL_MV:  prod_q <= PROD_W'(ma_q) * PROD_W'(vb_q);
			OP_ACC_LD:  acc_q  <= va_q;
			OP_ACC_SUB: acc_q  <= sat64(PROD_W'(acc_q) - PROD_W'(ms));
			OP_SUM_CLR: sum_q  <= '0;
			OP_SUM_ADD: sum_q  <= sum_q + SUM_W'(ms);
			OP_L_LD:    l_q    <= quo;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.o_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.o_ld) begin
			sol_index_q <= cmd.o_sing ? '0 : cmd.o_idx;
			sol_value_q <= cmd.o_sing ? '0 : va_q;
			status_q    <= cmd.o_sing;
			last_q      <= cmd.o_last;
		end
	end

	assign sts.gt       = ma_mag > bmag_q;
	assign sts.sing     = bmag_q <= MAG_W'(pivot_threshold);
	assign sts.div_busy = div_busy;
	assign sts.div_done = div_done;
	assign sts.out_busy = out_valid_q;

	assign out_valid = out_valid_q;
	assign sol_index = sol_index_q;
	assign sol_value = sol_value_q;
	assign status    = status_q;
	assign last      = last_q;

	`LUPS_ASSERT_IMP(a_out_free, cmd.o_ld, !out_valid_q, "Result loaded over a pending one.")
	`LUPS_ASSERT_IMP(a_div_idle, div_start, !div_busy, "Divider started while busy.")
	`LUPS_ASSERT_NXT(a_div_runs, div_start, div_busy, "Divider did not start.")

endmodule

[sv/lu_pivot_linear_solver.sv]
// Solves A x = b in signed Q16.16 by LU factorization with partial pivoting. Load requests
// (func 0 matrix entry, func 1 right-hand-side entry) are taken one per cycle while the block
// is idle; a solve request (func 2) occupies the block until its last result is loaded. Each
// update step reads, multiplies and writes back through the single write port of the matrix
// memory, and the serial divider is used once per multiplier and once per unknown.
// A solve emits x[0] to x[n-1] with last on x[n-1], or one result with status 1 when a pivot
// magnitude is at or below pivot_threshold. The stores hold no reset value and need no
// clearing pass; register 0 (matrix_size) sits at address 0, register 1 (pivot_threshold)
// at address 4.
module lu_pivot_linear_solver (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [lups_pkg::FUNC_W-1:0]         func,
	input  logic [lups_pkg::IDX_W-1:0]          row_index,
	input  logic [lups_pkg::IDX_W-1:0]          col_index,
	input  logic signed [lups_pkg::DATA_W-1:0]  value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [lups_pkg::IDX_W-1:0]          sol_index,
	output logic signed [lups_pkg::DATA_W-1:0]  sol_value,
	output logic                                status,
	output logic                                last
);
	import lups_pkg::*;

	localparam logic REG_SIZE = 1'b0;
	localparam logic REG_THR  = 1'b1;

	logic [SIZE_W-1:0] size_q;
	logic [THR_W-1:0]  thr_q;
	cmd_t              cmd;
	sts_t              sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(16);
			thr_q  <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_SIZE: size_q <= pwdata[SIZE_W-1:0];
				REG_THR:  thr_q  <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_THR) ? 32'(thr_q) : 32'(size_q);

	lups_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.row_index   (row_index),
		.col_index   (col_index),
		.matrix_size (size_q),
		.sts         (sts),
		.cmd         (cmd)
	);

	lups_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.value           (value),
		.pivot_threshold (thr_q),
		.sts             (sts),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.sol_index       (sol_index),
		.sol_value       (sol_value),
		.status          (status),
		.last            (last)
	);

endmodule
